/* rtl/core/integer_to_radix_digits_top_defines.svh */
// Assertion macros for the radix digit converter checker.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_TOP_DEFINES_SVH

// Property checked on every rising edge while reset is low
`define ITRD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define ITRD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/itrd_pkg.sv */
// Shared constants, types and the digit-to-ASCII function of the radix converter.
// No dependencies.
package itrd_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int DIGIT_WIDTH = 6;
   localparam int CHAR_WIDTH  = 7;
   localparam int RADIX_WIDTH = 6;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;

   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO     = 7'h30;
   localparam logic [CHAR_WIDTH-1:0]  ASCII_A        = 7'h41;
   localparam logic [DIGIT_WIDTH-1:0] DECIMAL_DIGITS = 6'd10;

   // Status handed from the divider to the sequencer
   typedef struct packed {
      logic done;
      logic quotient_zero;
   } div_status_type;

   // Map a digit value to '0'..'9' or 'A'..'Z'
   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d < DECIMAL_DIGITS) begin
         c = ASCII_ZERO + CHAR_WIDTH'(d);
      end else begin
         c = ASCII_A + CHAR_WIDTH'(d - DECIMAL_DIGITS);
      end
      return c;
   endfunction

endpackage

/* rtl/core/integer_to_radix_digits_top.sv */
// Radix digit converter: one 64-bit value in, its ASCII digits out, most significant first.
// Depends on itrd_pkg, itrd_div and itrd_ram.
//
// A request is taken when start is high and busy is low. Busy then stays high until the
// last character goes onto the outputs, and falls in the cycle that character is shown.
// Each digit costs one full pass of the shared bit-serial divider, and digits are stacked
// in a small RAM. The characters then leave one at a time, each through a RAM read and
// then the output register, each shown on rsp_digit_char for exactly one cycle with
// rsp_strobe high; the receiver cannot stall them. The next request can be taken in the
// same cycle that busy falls. Zero gives one '0'. The radix register resets to 10,
// saturates writes to 2..36, and must be written by the user only while busy is low;
// the block itself does not enforce this.
module integer_to_radix_digits_top #(
   parameter int MAX_DIGITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [itrd_pkg::VALUE_WIDTH-1:0]      req_value,
   output logic                                  rsp_strobe,
   output logic [itrd_pkg::CHAR_WIDTH-1:0]       rsp_digit_char,
   output logic                                  rsp_last_digit,
   input  logic                                  csr_write_enable,
   input  logic [itrd_pkg::RADIX_WIDTH-1:0]      csr_write_data
);
   import itrd_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_DIGITS);
   localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(MAX_DIGITS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_READ   = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [DIGIT_WIDTH-1:0] div_remainder;
   div_status_type         div_status;

   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [DIGIT_WIDTH-1:0] ram_rd_data;

   // Saturate radix writes into 2..36
   always_comb begin
      radix_in = radix_ff;
      if (csr_write_enable) begin
         priority if (csr_write_data < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (csr_write_data > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = csr_write_data;
         end
      end
   end

   // Sequencer: divide digit by digit, then pop the stack
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      div_start     = 1'b0;
      div_dividend  = div_quotient;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            div_dividend = req_value;
            if (start) begin
               div_start = 1'b1;
               count_in  = '0;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (count_ff < CNT_MAX) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
                  ptr_in    = count_ff[ADDR_W-1:0];
               end else begin
                  ptr_in    = ADDR_TOP;
               end
               if (div_status.quotient_zero) begin
                  state_in = ST_READ;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_char_in   = digit_to_ascii(ram_rd_data);
            rsp_last_in   = (ptr_ff == '0);
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         radix_ff      <= RADIX_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         radix_ff      <= radix_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Pointer and output payload
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   itrd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start_in  (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   itrd_ram #(
      .WIDTH (DIGIT_WIDTH),
      .DEPTH (MAX_DIGITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_remainder),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

endmodule

/* rtl/core/itrd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itrd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/itrd_div.sv */
// Restoring divider: 64-bit dividend by the radix, one quotient bit per cycle.
// Depends on itrd_pkg.
module itrd_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start_in,
   input  logic [itrd_pkg::VALUE_WIDTH-1:0]    dividend,
   input  logic [itrd_pkg::RADIX_WIDTH-1:0]    divisor,
   output logic [itrd_pkg::VALUE_WIDTH-1:0]    quotient,
   output logic [itrd_pkg::DIGIT_WIDTH-1:0]    remainder,
   output itrd_pkg::div_status_type            status
);
   import itrd_pkg::*;

   localparam int STEP_W = $clog2(VALUE_WIDTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_WIDTH - 1);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [DIGIT_WIDTH:0]   rem_shift;
   logic [DIGIT_WIDTH:0]   rem_sub;
   logic                   fits;

   // Shift in the next dividend bit and try the subtraction
   assign rem_shift = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, divisor};
   assign rem_sub   = rem_shift - {1'b0, divisor};

   // Load on start, otherwise advance one bit while running
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start_in) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? rem_sub[DIGIT_WIDTH-1:0] : rem_shift[DIGIT_WIDTH-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient             = quo_ff;
   assign remainder            = rem_ff;
   assign status.done          = done_ff;
   assign status.quotient_zero = (quo_ff == '0);

endmodule

/* rtl/core/itrd_checker.sv */
// Port-level checks for the radix digit converter, bound to the top level.
// Depends on itrd_pkg and integer_to_radix_digits_top_defines.svh.
`include "integer_to_radix_digits_top_defines.svh"

module itrd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_strobe,
   input logic [itrd_pkg::CHAR_WIDTH-1:0]   rsp_digit_char,
   input logic                              rsp_last_digit
);
   import itrd_pkg::*;

   logic char_ok;

   // Character must be a digit or an upper-case letter
   assign char_ok = ((rsp_digit_char >= ASCII_ZERO) && (rsp_digit_char <= 7'h39)) ||
                    ((rsp_digit_char >= ASCII_A) && (rsp_digit_char <= 7'h5A));

   `ITRD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy did not rise after a request")
   `ITRD_ASSERT(a_no_early_char, (start && !busy) |=> !rsp_strobe, "character right after request")
   `ITRD_ASSERT(a_strobe_from_busy, rsp_strobe |-> ($past(busy) && char_ok), "stray character")
   `ITRD_ASSERT(a_last_frees, (rsp_strobe && rsp_last_digit) |-> !busy, "busy after last char")

endmodule

bind integer_to_radix_digits_top itrd_checker u_checker (.*);

/* tb/integer_to_radix_digits_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_radix_digits_top: values in, ASCII digits out.
// Depends on itrd_pkg and the integer_to_radix_digits_top RTL.
module integer_to_radix_digits_top_tb;
   import itrd_pkg::*;

   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int DRAIN_CYCLES    = 200;
   localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;

   // Expected digit stream for every accepted request, in arrival order
   class digit_scoreboard;
      typedef struct packed {
         logic [CHAR_WIDTH-1:0] digit_char;
         logic                  last_digit;
      } digit_result_type;

      logic [RADIX_WIDTH-1:0] radix;
      digit_result_type       expected_digits[$];
      int unsigned            mismatches;

      function new();
         radix       = RADIX_RESET;
         mismatches  = 0;
      endfunction

      // Clamp the written base to the supported range
      function void set_radix(logic [RADIX_WIDTH-1:0] data);
         if (data < RADIX_MIN) begin
            radix = RADIX_MIN;
         end else if (data > RADIX_MAX) begin
            radix = RADIX_MAX;
         end else begin
            radix = data;
         end
      endfunction

      // Split the value into digits, least significant first, then queue them reversed
      function void note_request(logic [VALUE_WIDTH-1:0] value);
         logic [VALUE_WIDTH-1:0] quotient;
         logic [DIGIT_WIDTH-1:0] digits[$];
         digit_result_type       entry;
         quotient = value;
         do begin
            digits.push_back(DIGIT_WIDTH'(quotient % radix));
            quotient = quotient / radix;
         end while (quotient != 0);
         for (int i = digits.size() - 1; i >= 0; i--) begin
            if (digits[i] < DECIMAL_DIGITS) begin
               entry.digit_char = ASCII_ZERO + CHAR_WIDTH'(digits[i]);
            end else begin
               entry.digit_char = ASCII_A + CHAR_WIDTH'(digits[i]) - CHAR_WIDTH'(DECIMAL_DIGITS);
            end
            entry.last_digit = (i == 0);
            expected_digits.push_back(entry);
         end
      endfunction

      // Compare one strobed character with the oldest expected one
      function void check_digit(logic [CHAR_WIDTH-1:0] digit_char, logic last_digit);
         digit_result_type want;
         if (expected_digits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected digit: char %h last %b", digit_char, last_digit);
            end
         end else begin
            want = expected_digits.pop_front();
            if (digit_char !== want.digit_char || last_digit !== want.last_digit) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("digit error: expected char %h last %b, got char %h last %b",
                           want.digit_char, want.last_digit, digit_char, last_digit);
               end
            end
         end
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_strobe;
   logic [CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                   rsp_last_digit;
   logic                   csr_write_enable = 1'b0;
   logic [RADIX_WIDTH-1:0] csr_write_data = '0;

   digit_scoreboard sb = new();
   int              cycle_count;

   integer_to_radix_digits_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Check every strobed character against the predicted stream
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         sb.check_digit(rsp_digit_char, rsp_last_digit);
      end
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("integer_to_radix_digits_top: mismatch");
      $finish;
   end

   // Present a request and hold it until the block takes it; leave start high
   task send_value(logic [VALUE_WIDTH-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      sb.note_request(value);
   endtask

   // Drain all pending digits, then write the radix while idle
   task write_radix(logic [RADIX_WIDTH-1:0] data);
      start <= 1'b0;
      while (sb.pending() != 0 || busy !== 1'b0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_radix(data);
   endtask

   // Mostly random widths, with digit-count boundaries and extremes mixed in
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      logic [VALUE_WIDTH-1:0] v;
      logic [VALUE_WIDTH-1:0] power;
      int                     width;
      int                     sel;
      int                     steps;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         // land on r^k or r^k - 1
         power = 1;
         steps = $urandom_range(1, 64);
         for (int i = 0; i < steps; i++) begin
            if (power <= ALL_ONES / sb.radix) power = power * sb.radix;
         end
         v = ($urandom_range(0, 1) == 1) ? power : power - 1;
      end else if (sel == 1) begin
         v = ($urandom_range(0, 1) == 1) ? ALL_ONES : '0;
      end else begin
         width = $urandom_range(1, VALUE_WIDTH);
         v     = {$urandom, $urandom};
         if (width < VALUE_WIDTH) v = v & ((64'd1 << width) - 1);
      end
      return v;
   endfunction

   initial begin
      int burst_left;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset radix of ten
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(ALL_ONES);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'd12345678901234567890);

      // Directed: write below range, clamps to binary
      write_radix(6'd1);
      send_value(64'd0);
      send_value(ALL_ONES);
      send_value(64'd1);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h5555_5555_5555_5555);

      // Directed: top of range, 'Z' digits
      write_radix(RADIX_MAX);
      send_value(64'd35);
      send_value(64'd36);
      send_value(ALL_ONES);
      send_value(64'd0);

      // Directed: writes above range clamp to 36, zero clamps to 2
      write_radix(6'd63);
      send_value(64'd1295);
      write_radix(6'd0);
      send_value(64'd5);
      write_radix(6'd37);
      send_value(64'd46655);
      write_radix(6'd16);
      send_value(64'hFEDC_BA98_7654_3210);
      send_value(64'hA);

      // Random phases in bursts with gaps
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            write_radix(RADIX_MIN);
         end else if (p == 1) begin
            write_radix(RADIX_MAX);
         end else begin
            write_radix(RADIX_WIDTH'($urandom_range(0, 63)));
         end
         burst_left = 0;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
               start <= 1'b0;
               repeat ($urandom_range(1, 150)) @(posedge clock);
            end
            send_value(pick_value());
            burst_left--;
         end
      end

      // Drain and settle
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("integer_to_radix_digits_top: match");
      end else begin
         $display("integer_to_radix_digits_top: mismatch");
      end
      $finish;
   end

endmodule

/* integer_to_radix_digits_top.f */
+incdir+rtl/core
rtl/core/itrd_pkg.sv
rtl/core/itrd_ram.sv
rtl/core/itrd_div.sv
rtl/core/integer_to_radix_digits_top.sv
rtl/core/itrd_checker.sv
tb/integer_to_radix_digits_top_tb.sv
